// File: sv/slw_pkg.sv
package slw_pkg;

  localparam int COORD_FRAC_DEF = 16;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DISTORTION_A4   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNDISTORT_X_MIN = 3'd5;

  localparam logic [31:0] IMAGE_WIDTH_RST   = 32'd41943040;
  localparam logic [31:0] INVERSE_WIDTH_RST = 32'd6710886;
  localparam logic [31:0] CENTER_X_RST      = 32'd32768;
  localparam logic [31:0] CENTER_Y_RST      = 32'd24576;
  localparam logic [31:0] A4_RST            = 32'd0;
  localparam int          X_MIN_PIXELS      = 70;

  localparam logic FUNC_UNDISTORT = 1'b0;
  localparam logic FUNC_DISTORT   = 1'b1;

  localparam int R2_W       = 49;
  localparam int R2_EPS     = 43;
  localparam int NORM_W     = 58;
  localparam int DEN_W      = 58;
  localparam int DIV_BITS   = 48;
  localparam int SQRT_BITS  = 32;
  localparam int SQRT_REM_W = 34;

  typedef struct packed {
    logic               func;
    logic signed [31:0] pix_x;
    logic signed [31:0] pix_y;
  } slw_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               status;
  } slw_out_t;

endpackage

// File: sv/spherical_lens_warp.sv
// Spherical lens warp: each beat maps one signed Q16.16 pixel (x, y) through a radial lens
// model, undistorting (func 0) or distorting (func 1) it, and returns one result beat with
// saturated Q16.16 coordinates and a status bit (1: undistort denominator not positive, zero
// coordinates). The pipeline takes one beat per cycle unless the output is stalled; the
// 48-stage reciprocal divider and the 32-stage square root produce one result bit per
// stage. A stalled output freezes the whole pipeline. Configuration registers must be
// written only while no beat is in flight; the block itself does not enforce this.
module spherical_lens_warp #(
  parameter int COORD_FRAC_BITS = slw_pkg::COORD_FRAC_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  slw_pkg::slw_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output slw_pkg::slw_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [slw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);
  import slw_pkg::*;

  localparam int XT_SHIFT = 32 - COORD_FRAC_BITS;
  localparam logic [63:0] X_MIN_RST64 = 64'(X_MIN_PIXELS) << COORD_FRAC_BITS;

  // configuration
  logic        [31:0] img_w_r, inv_w_r, a4_r;
  logic signed [31:0] cx_r, cy_r, xmin_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= IMAGE_WIDTH_RST;
      inv_w_r <= INVERSE_WIDTH_RST;
      cx_r    <= CENTER_X_RST;
      cy_r    <= CENTER_Y_RST;
      a4_r    <= A4_RST;
      xmin_r  <= X_MIN_RST64[31:0];
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:     img_w_r <= cfg_data;
        CFG_INVERSE_WIDTH:   inv_w_r <= cfg_data;
        CFG_CENTER_X_OFFSET: cx_r    <= cfg_data;
        CFG_CENTER_Y_OFFSET: cy_r    <= cfg_data;
        CFG_DISTORTION_A4:   a4_r    <= cfg_data;
        CFG_UNDISTORT_X_MIN: xmin_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [63:0] xt, yt;
  assign xt = {{32{cx_r[31]}}, cx_r} << XT_SHIFT;
  assign yt = {{32{cy_r[31]}}, cy_r} << XT_SHIFT;

  logic adv, acc;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign acc      = in_valid && adv;

  // stage 1: clamp, scale by inverse width
  logic signed [31:0] px_c, py_c;
  logic        [31:0] px_mag, py_mag;
  logic        [63:0] pxp_nxt, pyp_nxt;
  assign px_c   = (in_data.func == FUNC_UNDISTORT && $signed(in_data.pix_x) < xmin_r) ?
                  xmin_r : in_data.pix_x;
  assign py_c   = in_data.pix_y;
  assign px_mag = px_c[31] ? (~px_c + 32'd1) : px_c;
  assign py_mag = py_c[31] ? (~py_c + 32'd1) : py_c;
  assign pxp_nxt = {32'd0, px_mag} * {32'd0, inv_w_r};
  assign pyp_nxt = {32'd0, py_mag} * {32'd0, inv_w_r};

  logic        v1_r, func1_r, pxn1_r, pyn1_r;
  logic [63:0] pxp1_r, pyp1_r;

  // stage 2: normalized coordinates
  logic [63:0] sx2, sy2, nx2_64, ny2_64;
  assign sx2    = pxp1_r >> COORD_FRAC_BITS;
  assign sy2    = pyp1_r >> COORD_FRAC_BITS;
  assign nx2_64 = (pxn1_r ? (64'd0 - sx2) : sx2) - xt;
  assign ny2_64 = (pyn1_r ? (64'd0 - sy2) : sy2) - yt;

  logic              v2_r, func2_r;
  logic [NORM_W-1:0] nx2_r, ny2_r;

  // stage 3: partial squares
  logic [NORM_W-1:0] ax3, ay3;
  assign ax3 = nx2_r[NORM_W-1] ? (~nx2_r + 1'b1) : nx2_r;
  assign ay3 = ny2_r[NORM_W-1] ? (~ny2_r + 1'b1) : ny2_r;

  logic              v3_r, func3_r, bigx3_r, bigy3_r;
  logic [NORM_W-1:0] nx3_r, ny3_r;
  logic [39:0]       xhh3_r, xhl3_r, xll3_r, yhh3_r, yhl3_r, yll3_r;

  // stage 4: squares
  logic [79:0]   xsq4, ysq4;
  logic [R2_W-1:0] sqx4_nxt, sqy4_nxt;
  assign xsq4 = ({40'd0, xhh3_r} << 40) + ({40'd0, xhl3_r} << 21) + {40'd0, xll3_r};
  assign ysq4 = ({40'd0, yhh3_r} << 40) + ({40'd0, yhl3_r} << 21) + {40'd0, yll3_r};
  assign sqx4_nxt = bigx3_r ? (R2_W'(1) << 48) : {1'b0, xsq4[79:32]};
  assign sqy4_nxt = bigy3_r ? (R2_W'(1) << 48) : {1'b0, ysq4[79:32]};

  logic              v4_r, func4_r;
  logic [NORM_W-1:0] nx4_r, ny4_r;
  logic [R2_W-1:0]   sqx4_r, sqy4_r;

  // stage 5: r2
  logic [R2_W:0]   r2sum5;
  logic [R2_W-1:0] r2_5_nxt;
  assign r2sum5   = {1'b0, sqx4_r} + {1'b0, sqy4_r};
  assign r2_5_nxt = (r2sum5 > ((R2_W+1)'(1) << 48)) ? (R2_W'(1) << 48) : r2sum5[R2_W-1:0];

  logic              v5_r, func5_r, small5_r;
  logic [NORM_W-1:0] nx5_r, ny5_r;
  logic [R2_W-1:0]   r2_5_r;

  // stage 6: r2 * a4 partials
  logic              v6_r, func6_r, small6_r;
  logic [NORM_W-1:0] nx6_r, ny6_r;
  logic [56:0]       pl6_r;
  logic [55:0]       ph6_r;

  // stage 7: denominator
  logic [81:0]      prod7;
  logic [57:0]      p7;
  logic [DEN_W-1:0] den7;
  logic             inv7;
  assign prod7 = ({26'd0, ph6_r} << 25) + {25'd0, pl6_r};
  assign p7    = prod7[81:24];
  assign inv7  = (func6_r == FUNC_UNDISTORT) && !small6_r && (p7[57:32] != '0);
  assign den7  = (func6_r == FUNC_UNDISTORT) ? ((DEN_W'(1) << 32) - p7) :
                                               ((DEN_W'(1) << 32) + p7);

  // divider: ratio = floor(2^64 / den), one quotient bit per stage
  logic                dv_r    [DIV_BITS+1];
  logic [DEN_W-1:0]    dden_r  [DIV_BITS+1];
  logic [DEN_W-1:0]    drem_r  [DIV_BITS+1];
  logic [DIV_BITS-1:0] dq_r    [DIV_BITS+1];
  logic [NORM_W-1:0]   dnx_r   [DIV_BITS+1];
  logic [NORM_W-1:0]   dny_r   [DIV_BITS+1];
  logic                dsat_r  [DIV_BITS+1];
  logic                dinv_r  [DIV_BITS+1];
  logic                dsmall_r[DIV_BITS+1];

  logic [DEN_W:0]      dsh     [DIV_BITS];
  logic                dge     [DIV_BITS];
  logic [DEN_W-1:0]    drem_nxt[DIV_BITS];
  logic [DIV_BITS-1:0] dq_nxt  [DIV_BITS];

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    assign dsh[k]      = {drem_r[k], 1'b0};
    assign dge[k]      = dsh[k] >= {1'b0, dden_r[k]};
    assign drem_nxt[k] = dge[k] ? DEN_W'(dsh[k] - {1'b0, dden_r[k]}) : dsh[k][DEN_W-1:0];
    assign dq_nxt[k]   = {dq_r[k][DIV_BITS-2:0], dge[k]};
  end

  // square root of ratio << 16, one root bit per stage
  logic                  sv_r    [SQRT_BITS+1];
  logic [63:0]           sval_r  [SQRT_BITS+1];
  logic [SQRT_REM_W-1:0] srem_r  [SQRT_BITS+1];
  logic [31:0]           sroot_r [SQRT_BITS+1];
  logic [NORM_W-1:0]     snx_r   [SQRT_BITS+1];
  logic [NORM_W-1:0]     sny_r   [SQRT_BITS+1];
  logic                  sinv_r  [SQRT_BITS+1];
  logic                  ssmall_r[SQRT_BITS+1];

  logic [SQRT_REM_W+1:0] sx      [SQRT_BITS];
  logic [SQRT_REM_W-1:0] st      [SQRT_BITS];
  logic                  sge     [SQRT_BITS];
  logic [SQRT_REM_W-1:0] srem_nxt[SQRT_BITS];

  for (genvar i = 0; i < SQRT_BITS; i++) begin : g_sqrt
    assign sx[i]       = {srem_r[i], sval_r[i][63:62]};
    assign st[i]       = {sroot_r[i], 2'b01};
    assign sge[i]      = sx[i] >= {2'b00, st[i]};
    assign srem_nxt[i] = sge[i] ? SQRT_REM_W'(sx[i] - {2'b00, st[i]}) :
                                  sx[i][SQRT_REM_W-1:0];
  end

  logic [DIV_BITS-1:0] ratio_d;
  assign ratio_d = dsat_r[DIV_BITS] ? '1 : dq_r[DIV_BITS];

  // M1: coordinate times sqrt(ratio), split partials
  logic [NORM_W-1:0] axm, aym;
  logic [31:0]       sm;
  assign axm = snx_r[SQRT_BITS][NORM_W-1] ? (~snx_r[SQRT_BITS] + 1'b1) : snx_r[SQRT_BITS];
  assign aym = sny_r[SQRT_BITS][NORM_W-1] ? (~sny_r[SQRT_BITS] + 1'b1) : sny_r[SQRT_BITS];
  assign sm  = ssmall_r[SQRT_BITS] ? 32'd0 : sroot_r[SQRT_BITS];

  logic        m1v_r, m1inv_r, m1xn_r, m1yn_r;
  logic [60:0] m1xlo_r, m1ylo_r;
  logic [59:0] m1xhi_r, m1yhi_r;

  // M2: recombine, cap, add offsets back
  logic [88:0] pxm2, pym2;
  logic [64:0] pxs2, pys2;
  logic [62:0] pxc2, pyc2;
  logic [63:0] mx2_nxt, my2_nxt;
  assign pxm2 = ({29'd0, m1xhi_r} << 29) + {28'd0, m1xlo_r};
  assign pym2 = ({29'd0, m1yhi_r} << 29) + {28'd0, m1ylo_r};
  assign pxs2 = pxm2[88:24];
  assign pys2 = pym2[88:24];
  assign pxc2 = (pxs2 > (65'd1 << 62)) ? (63'd1 << 62) : pxs2[62:0];
  assign pyc2 = (pys2 > (65'd1 << 62)) ? (63'd1 << 62) : pys2[62:0];
  assign mx2_nxt = (m1xn_r ? (64'd0 - {1'b0, pxc2}) : {1'b0, pxc2}) + xt;
  assign my2_nxt = (m1yn_r ? (64'd0 - {1'b0, pyc2}) : {1'b0, pyc2}) + yt;

  logic        m2v_r, m2inv_r;
  logic [63:0] mx2_r, my2_r;

  // M3: scale by image width, split partials
  logic [63:0] amx3, amy3;
  assign amx3 = mx2_r[63] ? (64'd0 - mx2_r) : mx2_r;
  assign amy3 = my2_r[63] ? (64'd0 - my2_r) : my2_r;

  logic        m3v_r, m3inv_r, m3xn_r, m3yn_r;
  logic [63:0] m3xlo_r, m3ylo_r;
  logic [62:0] m3xhi_r, m3yhi_r;

  // M4: recombine and saturate
  logic [63:0] rx4, ry4;
  logic [31:0] ox4, oy4;
  slw_out_t    out_nxt;
  assign rx4 = {1'b0, m3xhi_r} + (m3xlo_r >> 32);
  assign ry4 = {1'b0, m3yhi_r} + (m3ylo_r >> 32);
  assign ox4 = m3xn_r ? ((rx4[63:31] != '0) ? 32'h8000_0000 : (32'd0 - rx4[31:0])) :
                        ((rx4[63:31] != '0) ? 32'h7FFF_FFFF : rx4[31:0]);
  assign oy4 = m3yn_r ? ((ry4[63:31] != '0) ? 32'h8000_0000 : (32'd0 - ry4[31:0])) :
                        ((ry4[63:31] != '0) ? 32'h7FFF_FFFF : ry4[31:0]);
  always_comb begin
    out_nxt.out_x  = m3inv_r ? 32'd0 : ox4;
    out_nxt.out_y  = m3inv_r ? 32'd0 : oy4;
    out_nxt.status = m3inv_r;
  end

  logic     out_valid_r;
  slw_out_t out_data_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      for (int k = 0; k <= DIV_BITS; k++) dv_r[k] <= 1'b0;
      for (int i = 0; i <= SQRT_BITS; i++) sv_r[i] <= 1'b0;
      m1v_r       <= 1'b0;
      m2v_r       <= 1'b0;
      m3v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r    <= acc;
      func1_r <= in_data.func;
      pxn1_r  <= px_c[31];
      pyn1_r  <= py_c[31];
      pxp1_r  <= pxp_nxt;
      pyp1_r  <= pyp_nxt;

      v2_r    <= v1_r;
      func2_r <= func1_r;
      nx2_r   <= nx2_64[NORM_W-1:0];
      ny2_r   <= ny2_64[NORM_W-1:0];

      v3_r    <= v2_r;
      func3_r <= func2_r;
      nx3_r   <= nx2_r;
      ny3_r   <= ny2_r;
      bigx3_r <= ax3[NORM_W-1:40] != '0;
      bigy3_r <= ay3[NORM_W-1:40] != '0;
      xhh3_r  <= {20'd0, ax3[39:20]} * {20'd0, ax3[39:20]};
      xhl3_r  <= {20'd0, ax3[39:20]} * {20'd0, ax3[19:0]};
      xll3_r  <= {20'd0, ax3[19:0]}  * {20'd0, ax3[19:0]};
      yhh3_r  <= {20'd0, ay3[39:20]} * {20'd0, ay3[39:20]};
      yhl3_r  <= {20'd0, ay3[39:20]} * {20'd0, ay3[19:0]};
      yll3_r  <= {20'd0, ay3[19:0]}  * {20'd0, ay3[19:0]};

      v4_r    <= v3_r;
      func4_r <= func3_r;
      nx4_r   <= nx3_r;
      ny4_r   <= ny3_r;
      sqx4_r  <= sqx4_nxt;
      sqy4_r  <= sqy4_nxt;

      v5_r     <= v4_r;
      func5_r  <= func4_r;
      nx5_r    <= nx4_r;
      ny5_r    <= ny4_r;
      r2_5_r   <= r2_5_nxt;
      small5_r <= r2_5_nxt < R2_W'(R2_EPS);

      v6_r     <= v5_r;
      func6_r  <= func5_r;
      small6_r <= small5_r;
      nx6_r    <= nx5_r;
      ny6_r    <= ny5_r;
      pl6_r    <= {32'd0, r2_5_r[24:0]}  * {25'd0, a4_r};
      ph6_r    <= {32'd0, r2_5_r[48:25]} * {24'd0, a4_r};

      dv_r[0]     <= v6_r;
      dden_r[0]   <= den7;
      drem_r[0]   <= DEN_W'(1) << 16;
      dq_r[0]     <= '0;
      dnx_r[0]    <= nx6_r;
      dny_r[0]    <= ny6_r;
      dsat_r[0]   <= den7 <= (DEN_W'(1) << 16);
      dinv_r[0]   <= inv7;
      dsmall_r[0] <= small6_r;
      for (int k = 0; k < DIV_BITS; k++) begin
        dv_r[k+1]     <= dv_r[k];
        dden_r[k+1]   <= dden_r[k];
        drem_r[k+1]   <= drem_nxt[k];
        dq_r[k+1]     <= dq_nxt[k];
        dnx_r[k+1]    <= dnx_r[k];
        dny_r[k+1]    <= dny_r[k];
        dsat_r[k+1]   <= dsat_r[k];
        dinv_r[k+1]   <= dinv_r[k];
        dsmall_r[k+1] <= dsmall_r[k];
      end

      sv_r[0]     <= dv_r[DIV_BITS];
      sval_r[0]   <= {ratio_d, 16'd0};
      srem_r[0]   <= '0;
      sroot_r[0]  <= '0;
      snx_r[0]    <= dnx_r[DIV_BITS];
      sny_r[0]    <= dny_r[DIV_BITS];
      sinv_r[0]   <= dinv_r[DIV_BITS];
      ssmall_r[0] <= dsmall_r[DIV_BITS];
      for (int i = 0; i < SQRT_BITS; i++) begin
        sv_r[i+1]     <= sv_r[i];
        sval_r[i+1]   <= {sval_r[i][61:0], 2'b00};
        srem_r[i+1]   <= srem_nxt[i];
        sroot_r[i+1]  <= {sroot_r[i][30:0], sge[i]};
        snx_r[i+1]    <= snx_r[i];
        sny_r[i+1]    <= sny_r[i];
        sinv_r[i+1]   <= sinv_r[i];
        ssmall_r[i+1] <= ssmall_r[i];
      end

      m1v_r   <= sv_r[SQRT_BITS];
      m1inv_r <= sinv_r[SQRT_BITS];
      m1xn_r  <= snx_r[SQRT_BITS][NORM_W-1];
      m1yn_r  <= sny_r[SQRT_BITS][NORM_W-1];
      m1xlo_r <= {32'd0, axm[28:0]}  * {29'd0, sm};
      m1ylo_r <= {32'd0, aym[28:0]}  * {29'd0, sm};
      m1xhi_r <= {32'd0, axm[56:29]} * {28'd0, sm};
      m1yhi_r <= {32'd0, aym[56:29]} * {28'd0, sm};

      m2v_r   <= m1v_r;
      m2inv_r <= m1inv_r;
      mx2_r   <= mx2_nxt;
      my2_r   <= my2_nxt;

      m3v_r   <= m2v_r;
      m3inv_r <= m2inv_r;
      m3xn_r  <= mx2_r[63];
      m3yn_r  <= my2_r[63];
      m3xlo_r <= {32'd0, amx3[31:0]}  * {32'd0, img_w_r};
      m3ylo_r <= {32'd0, amy3[31:0]}  * {32'd0, img_w_r};
      m3xhi_r <= {32'd0, amx3[62:32]} * {31'd0, img_w_r};
      m3yhi_r <= {32'd0, amy3[62:32]} * {31'd0, img_w_r};

      out_valid_r <= m3v_r;
      out_data_r  <= out_nxt;
    end
  end

endmodule

// File: sv/slw_checker.sv
module slw_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input slw_pkg::slw_in_t              in_data,
  input logic                          out_valid,
  input logic                          out_stall,
  input slw_pkg::slw_out_t             out_data,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [slw_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [31:0]                   cfg_data
);
  import slw_pkg::*;

  logic unused_ok;
  assign unused_ok = in_valid ^ cfg_valid ^ (^in_data) ^ (^cfg_index) ^ (^cfg_data);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.out_x == 0 && out_data.out_y == 0)
    else $error("invalid result carries nonzero coordinates");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && cfg_ready)
    else $error("output valid or config not ready after reset");

endmodule

bind spherical_lens_warp slw_checker u_slw_checker (.*);
